// File: rtl/core/etok_pkg.sv
package etok_pkg;

  // sizes
  localparam int NAME_CHARS = 8;
  localparam int VALUE_BITS = 31;
  localparam int VALUE_W    = 31;
  localparam int NAME_W     = 64;
  localparam int WIDE_W     = VALUE_BITS + 4;

  // character codes
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  typedef enum logic [2:0] {
    KIND_NUMBER = 3'd0,
    KIND_NAME   = 3'd1,
    KIND_OPER   = 3'd2,
    KIND_LPAREN = 3'd3,
    KIND_RPAREN = 3'd4,
    KIND_END    = 3'd5,
    KIND_ERROR  = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    OP_PLUS   = 2'd0,
    OP_MINUS  = 2'd1,
    OP_TIMES  = 2'd2,
    OP_DIVIDE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNKNOWN   = 2'd1,
    ERR_BAD_NUM   = 2'd2,
    ERR_TOO_LONG  = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_NAME   = 2'd2,
    MODE_END    = 2'd3
  } mode_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       at_end;
  } in_t;

  typedef struct packed {
    kind_e               kind;
    logic [VALUE_W-1:0]  value;
    logic                value_overflow;
    op_e                 operator_code;
    logic [NAME_W-1:0]   name_text;
    logic [3:0]          name_length;
    err_e                error_code;
    logic [7:0]          bad_char;
    logic                last;
  } out_t;

  // words pushed into the result queue by one input word
  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } push_t;

endpackage

// File: rtl/core/etok_queue.sv
module etok_queue import etok_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  full_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output out_t  out_data_o
);

  out_t       mem_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  // room for two words is needed before a new input word is taken
  assign full_o      = (cnt_q > 3'd2);
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o & ~out_stall_i;

  // pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q + push_i.count;
    rd_ptr_d = rd_ptr_q + {1'b0, pop};
    cnt_d    = cnt_q + {1'b0, push_i.count} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + 2'd1] <= push_i.second;
    end
  end

endmodule

// File: rtl/core/expression_tokenizer.sv
// Lexer for arithmetic expression text. Each input word carries one ASCII
// character, or an end mark (a newline ends input too); the block returns
// number, name, operator, paren, end and error tokens, with last set on the
// final token of each input word. A character is taken every cycle while the
// result queue has room, and its tokens are registered into it. A word that
// closes a number or name and is itself a token gives two tokens, which leave
// one per cycle unless the output stalls, through a four-word result queue;
// input stalls while that queue has fewer than two free slots. After end the
// block answers end to every word until reset.
module expression_tokenizer import etok_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam logic [VALUE_BITS-1:0] VMAX = {VALUE_BITS{1'b1}};

  mode_e                 mode_q, mode_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic                  ovf_q, ovf_d;
  logic                  bad_q, bad_d;
  logic [NAME_W-1:0]     nbuf_q, nbuf_d;
  logic [3:0]            ncnt_q, ncnt_d;
  logic                  nlong_q, nlong_d;

  logic        accept;
  logic        full;
  logic [7:0]  c;
  logic        endc;
  logic        is_digit, is_alpha, is_space, is_oper;
  logic [3:0]  digit;
  logic [WIDE_W-1:0] prod;
  logic        prod_ovf;
  logic        closing;
  logic        fresh;
  logic        idle_emit;
  out_t        idle_res;
  out_t        close_res;
  push_t       push;

  assign accept     = in_valid_i & ~full;
  assign in_stall_o = full;

  // character classes
  always_comb begin
    c        = in_data_i.char_code;
    endc     = in_data_i.at_end | (c == CH_NEWLINE);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    is_alpha = ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    is_oper  = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
    digit    = 4'(c - CH_ZERO);
  end

  // accumulate: acc * 10 + digit, saturating
  always_comb begin
    prod     = (WIDE_W'(acc_q) << 3) + (WIDE_W'(acc_q) << 1) + WIDE_W'(digit);
    prod_ovf = (prod > WIDE_W'(VMAX));
  end

  // a number or name closes at end or on any character that is neither a digit nor a letter
  always_comb begin
    unique case (mode_q)
      MODE_NUMBER: closing = endc | ~(is_digit | is_alpha);
      MODE_NAME:   closing = endc | ~(is_digit | is_alpha);
      default:     closing = 1'b0;
    endcase
    fresh = (mode_q == MODE_IDLE) | closing;
  end

  // token for a character seen in idle
  always_comb begin
    idle_res  = '0;
    idle_emit = 1'b1;
    priority if (endc) begin
      idle_res.kind = KIND_END;
    end else if (is_space || is_digit || is_alpha) begin
      idle_emit = 1'b0;
    end else if (is_oper) begin
      idle_res.kind = KIND_OPER;
      unique case (c)
        CH_PLUS:  idle_res.operator_code = OP_PLUS;
        CH_MINUS: idle_res.operator_code = OP_MINUS;
        CH_STAR:  idle_res.operator_code = OP_TIMES;
        default:  idle_res.operator_code = OP_DIVIDE;
      endcase
    end else if (c == CH_LPAREN) begin
      idle_res.kind = KIND_LPAREN;
    end else if (c == CH_RPAREN) begin
      idle_res.kind = KIND_RPAREN;
    end else begin
      idle_res.kind       = KIND_ERROR;
      idle_res.error_code = ERR_UNKNOWN;
      idle_res.bad_char   = c;
    end
  end

  // token for a number or name that closes
  always_comb begin
    close_res = '0;
    if (mode_q == MODE_NUMBER) begin
      if (bad_q) begin
        close_res.kind       = KIND_ERROR;
        close_res.error_code = ERR_BAD_NUM;
      end else begin
        close_res.kind           = KIND_NUMBER;
        close_res.value          = VALUE_W'(acc_q);
        close_res.value_overflow = ovf_q;
      end
    end else if (nlong_q) begin
      close_res.kind       = KIND_ERROR;
      close_res.error_code = ERR_TOO_LONG;
    end else begin
      close_res.kind        = KIND_NAME;
      close_res.name_text   = nbuf_q;
      close_res.name_length = ncnt_q;
    end
  end

  // next state
  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    bad_d   = bad_q;
    nbuf_d  = nbuf_q;
    ncnt_d  = ncnt_q;
    nlong_d = nlong_q;
    if (accept) begin
      if (fresh) begin
        // fresh character, also the one that closes a token
        mode_d = MODE_IDLE;
        priority if (endc) begin
          mode_d = MODE_END;
        end else if (is_digit) begin
          mode_d = MODE_NUMBER;
          acc_d  = VALUE_BITS'(digit);
          ovf_d  = 1'b0;
          bad_d  = 1'b0;
        end else if (is_alpha) begin
          mode_d  = MODE_NAME;
          nbuf_d  = NAME_W'(c);
          ncnt_d  = 4'd1;
          nlong_d = 1'b0;
        end else begin
          mode_d = MODE_IDLE;
        end
      end else if (mode_q == MODE_NUMBER) begin
        if (is_digit) begin
          if (prod_ovf) begin
            acc_d = VMAX;
            ovf_d = 1'b1;
          end else begin
            acc_d = VALUE_BITS'(prod);
          end
        end else begin
          bad_d = 1'b1;
        end
      end else if (mode_q == MODE_NAME) begin
        if (ncnt_q < 4'(NAME_CHARS)) begin
          for (int i = 0; i < NAME_CHARS; i++) begin
            if (ncnt_q == 4'(i)) begin
              nbuf_d[8*i +: 8] = c;
            end
          end
          ncnt_d = ncnt_q + 4'd1;
        end else begin
          nlong_d = 1'b1;
        end
      end
    end
  end

  // result words for the queue
  always_comb begin
    push        = '0;
    push.first  = close_res;
    push.second = idle_res;
    if (accept) begin
      if (mode_q == MODE_END) begin
        push.first      = '0;
        push.first.kind = KIND_END;
        push.first.last = 1'b1;
        push.count      = 2'd1;
      end else if (closing) begin
        push.count = idle_emit ? 2'd2 : 2'd1;
        push.first.last  = ~idle_emit;
        push.second.last = 1'b1;
      end else if (mode_q == MODE_IDLE) begin
        push.first      = idle_res;
        push.first.last = 1'b1;
        push.count      = {1'b0, idle_emit};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      bad_q   <= 1'b0;
      nbuf_q  <= '0;
      ncnt_q  <= '0;
      nlong_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      bad_q   <= bad_d;
      nbuf_q  <= nbuf_d;
      ncnt_q  <= ncnt_d;
      nlong_q <= nlong_d;
    end
  end

  etok_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
